// File: design/ecr_pkg.sv
// Shared types and codes for the elastic collision response block.
`default_nettype none
package ecr_pkg;

  typedef enum logic [1:0] {
    OC_APPLIED    = 2'd0,
    OC_SEPARATING = 2'd1,
    OC_COINCIDENT = 2'd2,
    OC_SATURATED  = 2'd3
  } outcome_e;

endpackage
`default_nettype wire

// File: design/ecr_dly.sv
// Enabled shift-register delay line for side data that travels with the pipeline.
`default_nettype none
module ecr_dly #(
  parameter int DW = 8,
  parameter int N  = 2
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [DW-1:0] d_i,
  output logic      [DW-1:0] q_o
);

  logic [DW-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule
`default_nettype wire

// File: design/ecr_mul.sv
// Two-stage unsigned multiplier: chunked partial products, then a registered sum.
`default_nettype none
module ecr_mul #(
  parameter int AW = 64,
  parameter int BW = 32,
  parameter int CW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic      [AW+BW-1:0] p_o
);

  localparam int NC = (AW + CW - 1) / CW;
  localparam int PW = NC * CW;
  localparam int SW = PW + BW;

  logic [PW-1:0]      ax;
  logic [CW+BW-1:0]   pp_q [NC];
  logic [SW-1:0]      acc;
  logic [AW+BW-1:0]   p_q;

  assign ax = PW'(a_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NC; i++) begin
        pp_q[i] <= (CW+BW)'(ax[i*CW +: CW]) * (CW+BW)'(b_i);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NC; i++) begin
      acc = acc + (SW'(pp_q[i]) << (i*CW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[AW+BW-1:0];
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: design/ecr_div.sv
// Pipelined restoring divider: rounded quotient, one bit per stage, with overflow flag.
`default_nettype none
module ecr_div #(
  parameter int NW = 131,
  parameter int DW = 99,
  parameter int QB = 33
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QB-1:0] quo_o,
  output logic               big_o
);

  localparam int RW = (NW + 3 > DW + 1 + QB) ? NW + 3 : DW + 1 + QB;

  // rounding: (4*num + den) / (2*den)
  logic [RW-1:0] r0_c;
  logic [DW:0]   d0_c;
  logic [RW-1:0] r_q [QB];
  logic [DW:0]   d_q [QB];
  logic          b_q [QB+1];
  logic [QB-1:0] q_q [1:QB];

  assign r0_c = (RW'(num_i) << 2) + RW'(den_i);
  assign d0_c = {den_i, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= r0_c;
      d_q[0] <= d0_c;
      b_q[0] <= (r0_c >= (RW'(d0_c) << QB));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    logic [QB-1:0] qprev;

    assign sh = RW'(d_q[k-1]) << (QB - k);
    assign ge = (r_q[k-1] >= sh);

    if (k == 1) begin : g_q0
      assign qprev = '0;
    end else begin : g_qn
      assign qprev = q_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k] <= qprev | (ge ? (QB'(1) << (QB - k)) : '0);
        b_q[k] <= b_q[k-1];
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k] <= ge ? (r_q[k-1] - sh) : r_q[k-1];
          d_q[k] <= d_q[k-1];
        end
      end
    end
  end

  assign quo_o = q_q[QB];
  assign big_o = b_q[QB];

endmodule
`default_nettype wire

// File: design/elastic_collision_response.sv
// Top level of the two-body 3D elastic collision response pipeline.
`default_nettype none
// Takes one body pair per cycle while the output is not stalled. The six restoring
// dividers resolve one quotient bit per stage; the input and dot-product stages, the
// chunked multipliers, the dividers' entry stage and the output register add ten more.
// A stall on the output freezes the whole pipeline in place.
module elastic_collision_response #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic        [WORD_BITS-1:0] first_mass_i,
  input  wire logic        [WORD_BITS-1:0] second_mass_i,
  input  wire logic signed [WORD_BITS-1:0] first_vel_x_i,
  input  wire logic signed [WORD_BITS-1:0] first_vel_y_i,
  input  wire logic signed [WORD_BITS-1:0] first_vel_z_i,
  input  wire logic signed [WORD_BITS-1:0] second_vel_x_i,
  input  wire logic signed [WORD_BITS-1:0] second_vel_y_i,
  input  wire logic signed [WORD_BITS-1:0] second_vel_z_i,
  input  wire logic signed [WORD_BITS-1:0] centre_diff_x_i,
  input  wire logic signed [WORD_BITS-1:0] centre_diff_y_i,
  input  wire logic signed [WORD_BITS-1:0] centre_diff_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed      [WORD_BITS-1:0] new_first_vel_x_o,
  output logic signed      [WORD_BITS-1:0] new_first_vel_y_o,
  output logic signed      [WORD_BITS-1:0] new_first_vel_z_o,
  output logic signed      [WORD_BITS-1:0] new_second_vel_x_o,
  output logic signed      [WORD_BITS-1:0] new_second_vel_y_o,
  output logic signed      [WORD_BITS-1:0] new_second_vel_z_o,
  output ecr_pkg::outcome_e                outcome_o
);

  import ecr_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int QB  = W + 1;
  localparam int L   = QB + 10;
  localparam int SAW = 6*W + 6;
  localparam int SBW = 3*W + 1;

  localparam logic signed [W+2:0] HI = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] LO = {4'b1111, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic [L-1:0] vld_q;

  // input stage
  logic [W-1:0] va_c [3];
  logic [W-1:0] vb_c [3];
  logic [W-1:0] dc_c [3];
  logic [W:0]   dv_c [3];
  logic [W:0]   dvm_c [3];
  logic [W-1:0] dcm_c [3];

  logic [W-1:0] s1_va_q [3];
  logic [W-1:0] s1_vb_q [3];
  logic [W:0]   s1_dvm_q [3];
  logic         s1_dvs_q [3];
  logic [W-1:0] s1_dcm_q [3];
  logic         s1_dcs_q [3];
  logic [W-1:0] s1_ma_q;
  logic [W-1:0] s1_mb_q;
  logic [W:0]   s1_m_q;
  logic         s1_coin_q;

  logic [2*W:0]   s2_p_q [3];
  logic [2*W-1:0] s2_sq_q [3];
  logic           s2_ps_q [3];

  logic [2*W+3:0] dot_c;
  logic [2*W+1:0] dd_c;
  logic [2*W+3:0] s3_dot_q;
  logic [2*W+1:0] s3_dd_q;

  logic [2*W+3:0] dotm_c;
  logic [2*W+2:0] s4_dotm_q;
  logic [2*W+1:0] s4_dd_q;
  logic           s4_dotneg_q;
  logic           s4_dotnz_q;

  logic [SAW-1:0] side_a_d, side_a_q;
  logic [SBW-1:0] side_b_d, side_b_q;
  logic [1:0]     side_c_d, side_c_q;
  logic [3*W-1:0] side_d_d, side_d_q;

  logic [W-1:0]   ma4, mb4;
  logic [W:0]     m4;
  logic [3*W+2:0] den6, kam6, kbm6, den8;
  logic [W-1:0]   dcm6 [3];
  logic [4*W+2:0] na8 [3];
  logic [4*W+2:0] nb8 [3];
  logic [QB-1:0]  qa [3];
  logic [QB-1:0]  qb [3];
  logic           biga [3];
  logic           bigb [3];

  logic [W-1:0]   fva [3];
  logic [W-1:0]   fvb [3];
  logic           fdcs [3];
  logic           f_manz, f_mnz, f_coin, f_dotneg, f_dotnz, f_sep;

  logic [W-1:0]   res_c [6];
  logic [W-1:0]   res_q [6];
  logic [W:0]     ca [3];
  logic [W:0]     cb [3];
  logic           sat_c;
  outcome_e       oc_c, oc_q;

  function automatic logic [W:0] clampf(logic signed [W+2:0] v, logic big, logic up);
    logic [W:0] r;
    if (big) begin
      r = up ? {1'b1, HI[W-1:0]} : {1'b1, LO[W-1:0]};
    end else if (v > HI) begin
      r = {1'b1, HI[W-1:0]};
    end else if (v < LO) begin
      r = {1'b1, LO[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic is_ext(logic [W-1:0] x);
    return (x == MAXW) || (x == MINW);
  endfunction

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  assign va_c[0] = first_vel_x_i;
  assign va_c[1] = first_vel_y_i;
  assign va_c[2] = first_vel_z_i;
  assign vb_c[0] = second_vel_x_i;
  assign vb_c[1] = second_vel_y_i;
  assign vb_c[2] = second_vel_z_i;
  assign dc_c[0] = centre_diff_x_i;
  assign dc_c[1] = centre_diff_y_i;
  assign dc_c[2] = centre_diff_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_c[i]  = {va_c[i][W-1], va_c[i]} - {vb_c[i][W-1], vb_c[i]};
      dvm_c[i] = dv_c[i][W] ? (~dv_c[i] + 1'b1) : dv_c[i];
      dcm_c[i] = dc_c[i][W-1] ? (~dc_c[i] + 1'b1) : dc_c[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_va_q[i]  <= va_c[i];
        s1_vb_q[i]  <= vb_c[i];
        s1_dvm_q[i] <= dvm_c[i];
        s1_dvs_q[i] <= dv_c[i][W];
        s1_dcm_q[i] <= dcm_c[i];
        s1_dcs_q[i] <= dc_c[i][W-1];
      end
      s1_ma_q   <= first_mass_i;
      s1_mb_q   <= second_mass_i;
      s1_m_q    <= {1'b0, first_mass_i} + {1'b0, second_mass_i};
      s1_coin_q <= (dc_c[0] == '0) && (dc_c[1] == '0) && (dc_c[2] == '0);
    end
  end

  // per-axis products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_p_q[i]  <= (2*W+1)'(s1_dvm_q[i]) * (2*W+1)'(s1_dcm_q[i]);
        s2_sq_q[i] <= (2*W)'(s1_dcm_q[i]) * (2*W)'(s1_dcm_q[i]);
        s2_ps_q[i] <= s1_dvs_q[i] ^ s1_dcs_q[i];
      end
    end
  end

  always_comb begin
    dot_c = '0;
    dd_c  = '0;
    for (int i = 0; i < 3; i++) begin
      dot_c = s2_ps_q[i] ? (dot_c - (2*W+4)'(s2_p_q[i])) : (dot_c + (2*W+4)'(s2_p_q[i]));
      dd_c  = dd_c + (2*W+2)'(s2_sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_dot_q <= dot_c;
      s3_dd_q  <= dd_c;
    end
  end

  assign dotm_c = s3_dot_q[2*W+3] ? (~s3_dot_q + 1'b1) : s3_dot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_dotm_q   <= dotm_c[2*W+2:0];
      s4_dd_q     <= s3_dd_q;
      s4_dotneg_q <= s3_dot_q[2*W+3];
      s4_dotnz_q  <= |s3_dot_q;
    end
  end

  // side data
  assign side_a_d = {s1_va_q[0], s1_va_q[1], s1_va_q[2], s1_vb_q[0], s1_vb_q[1], s1_vb_q[2],
                     s1_dcs_q[0], s1_dcs_q[1], s1_dcs_q[2], |s1_ma_q, |s1_m_q, s1_coin_q};
  assign side_b_d = {s1_ma_q, s1_mb_q, s1_m_q};
  assign side_c_d = {s4_dotneg_q, s4_dotnz_q};
  assign side_d_d = {s1_dcm_q[0], s1_dcm_q[1], s1_dcm_q[2]};

  ecr_dly #(.DW(SAW), .N(L-2)) u_dly_a (
    .clk_i, .en_i(en), .d_i(side_a_d), .q_o(side_a_q)
  );
  ecr_dly #(.DW(SBW), .N(3)) u_dly_b (
    .clk_i, .en_i(en), .d_i(side_b_d), .q_o(side_b_q)
  );
  ecr_dly #(.DW(2), .N(L-5)) u_dly_c (
    .clk_i, .en_i(en), .d_i(side_c_d), .q_o(side_c_q)
  );
  ecr_dly #(.DW(3*W), .N(5)) u_dly_d (
    .clk_i, .en_i(en), .d_i(side_d_d), .q_o(side_d_q)
  );
  ecr_dly #(.DW(3*W+3), .N(2)) u_dly_e (
    .clk_i, .en_i(en), .d_i(den6), .q_o(den8)
  );

  assign ma4 = side_b_q[3*W:2*W+1];
  assign mb4 = side_b_q[2*W:W+1];
  assign m4  = side_b_q[W:0];

  // den = M*dd, ka = mb*|dot|, kb = ma*|dot|
  ecr_mul #(.AW(2*W+2), .BW(W+1), .CW(W)) u_mul_den (
    .clk_i, .en_i(en), .a_i(s4_dd_q), .b_i(m4), .p_o(den6)
  );
  ecr_mul #(.AW(2*W+3), .BW(W), .CW(W)) u_mul_ka (
    .clk_i, .en_i(en), .a_i(s4_dotm_q), .b_i(mb4), .p_o(kam6)
  );
  ecr_mul #(.AW(2*W+3), .BW(W), .CW(W)) u_mul_kb (
    .clk_i, .en_i(en), .a_i(s4_dotm_q), .b_i(ma4), .p_o(kbm6)
  );

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign dcm6[i] = side_d_q[3*W-1-i*W -: W];
    assign fva[i]  = side_a_q[SAW-1-i*W -: W];
    assign fvb[i]  = side_a_q[SAW-1-(3+i)*W -: W];
    assign fdcs[i] = side_a_q[5-i];

    ecr_mul #(.AW(3*W+3), .BW(W), .CW(W)) u_mul_na (
      .clk_i, .en_i(en), .a_i(kam6), .b_i(dcm6[i]), .p_o(na8[i])
    );
    ecr_mul #(.AW(3*W+3), .BW(W), .CW(W)) u_mul_nb (
      .clk_i, .en_i(en), .a_i(kbm6), .b_i(dcm6[i]), .p_o(nb8[i])
    );
    ecr_div #(.NW(4*W+3), .DW(3*W+3), .QB(QB)) u_div_a (
      .clk_i, .en_i(en), .num_i(na8[i]), .den_i(den8), .quo_o(qa[i]), .big_o(biga[i])
    );
    ecr_div #(.NW(4*W+3), .DW(3*W+3), .QB(QB)) u_div_b (
      .clk_i, .en_i(en), .num_i(nb8[i]), .den_i(den8), .quo_o(qb[i]), .big_o(bigb[i])
    );
  end

  assign f_manz   = side_a_q[2];
  assign f_mnz    = side_a_q[1];
  assign f_coin   = side_a_q[0];
  assign f_dotneg = side_c_q[1];
  assign f_dotnz  = side_c_q[0];
  assign f_sep    = f_manz && !f_dotneg && f_dotnz;

  // final add and clamp; a negative impulse sign pushes the first body up
  always_comb begin
    sat_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (f_dotneg ^ fdcs[i]) begin
        ca[i] = clampf(signed'({{3{fva[i][W-1]}}, fva[i]}) + signed'({2'b00, qa[i]}),
                       biga[i], 1'b1);
        cb[i] = clampf(signed'({{3{fvb[i][W-1]}}, fvb[i]}) - signed'({2'b00, qb[i]}),
                       bigb[i], 1'b0);
      end else begin
        ca[i] = clampf(signed'({{3{fva[i][W-1]}}, fva[i]}) - signed'({2'b00, qa[i]}),
                       biga[i], 1'b0);
        cb[i] = clampf(signed'({{3{fvb[i][W-1]}}, fvb[i]}) + signed'({2'b00, qb[i]}),
                       bigb[i], 1'b1);
      end
      sat_c = sat_c | ca[i][W] | cb[i][W];
    end
    for (int i = 0; i < 3; i++) begin
      res_c[i]   = fva[i];
      res_c[3+i] = fvb[i];
    end
    oc_c = OC_APPLIED;
    if (f_coin) begin
      oc_c = OC_COINCIDENT;
    end else if (f_sep) begin
      oc_c = OC_SEPARATING;
    end else if (f_mnz) begin
      for (int i = 0; i < 3; i++) begin
        res_c[i]   = ca[i][W-1:0];
        res_c[3+i] = cb[i][W-1:0];
      end
      oc_c = sat_c ? OC_SATURATED : OC_APPLIED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_c;
      oc_q  <= oc_c;
    end
  end

  assign out_valid_o        = vld_q[L-1];
  assign new_first_vel_x_o  = res_q[0];
  assign new_first_vel_y_o  = res_q[1];
  assign new_first_vel_z_o  = res_q[2];
  assign new_second_vel_x_o = res_q[3];
  assign new_second_vel_y_o = res_q[4];
  assign new_second_vel_z_o = res_q[5];
  assign outcome_o          = oc_q;

`ifndef SYNTH
  a_sat_has_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OC_SATURATED) |->
      is_ext(res_q[0]) || is_ext(res_q[1]) || is_ext(res_q[2]) ||
      is_ext(res_q[3]) || is_ext(res_q[4]) || is_ext(res_q[5]))
    else $error("saturated outcome without a clamped component");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost at pipeline entry");
`endif

endmodule
`default_nettype wire
